// ===== sv/mi3inv_pkg.sv =====
// Shared constants, types and the divider step for the 3x3 fixed-point inverse.
// Used by mi3inv_div and matrix3_inverse_fx12_core; no dependencies.
`default_nettype none

package mi3inv_pkg;

  localparam int unsigned ElemW = 32;
  localparam int unsigned NumElem = 9;
  // low product bits that still reach a 32-bit result after the shift by 12
  localparam int unsigned ProdW = 44;
  localparam int unsigned FracW = 12;
  localparam logic [ProdW-1:0] RoundHalf = 44'h800;

  // reciprocal: 2^44 / |det| gives up to 45 quotient bits
  localparam int unsigned QuoW = 45;
  localparam int unsigned DivStepsPerStage = 3;
  localparam int unsigned DivStages = QuoW / DivStepsPerStage;
  localparam int unsigned RecipW = 52;
  localparam logic [RecipW-1:0] RecipHalf = 52'h8_0000;
  localparam int unsigned RecipShift = 20;

  // cofactor order: c00 c01 c02 c10 c11 c12 c20 c21 c22
  localparam logic [NumElem-1:0] NegMask = 9'b0_1010_1010;
  localparam logic [NumElem-1:0] RoundMask = 9'b0_0100_1001;

  typedef logic [3:0] idx_t;

  // minor = m[A]*m[B] - m[C]*m[D], inputs indexed row*3+column
  localparam idx_t MinA [NumElem] = '{4'd4, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0};
  localparam idx_t MinB [NumElem] = '{4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd5, 4'd7, 4'd7, 4'd4};
  localparam idx_t MinC [NumElem] = '{4'd5, 4'd7, 4'd4, 4'd5, 4'd6, 4'd3, 4'd4, 4'd6, 4'd3};
  localparam idx_t MinD [NumElem] = '{4'd7, 4'd2, 4'd2, 4'd6, 4'd2, 4'd2, 4'd6, 4'd1, 4'd1};

  typedef logic [ElemW-1:0] word_t;
  typedef word_t [NumElem-1:0] mat_t;

  typedef struct packed {
    logic [ElemW-1:0] rem;
    logic [QuoW-1:0]  quo;
    logic [ElemW-1:0] dmag;
    logic             neg;
    logic             sing;
    mat_t             cof;
  } div_st_t;

  // One restoring division step: shift in a numerator bit, subtract if it fits.
  function automatic div_st_t div_step(div_st_t x, logic nb);
    logic [ElemW:0] r;
    logic [ElemW:0] t;
    div_st_t        y;
    y = x;
    r = {x.rem, nb};
    t = r - {1'b0, x.dmag};
    if (!t[ElemW]) begin
      y.rem = t[ElemW-1:0];
      y.quo = {x.quo[QuoW-2:0], 1'b1};
    end else begin
      y.rem = r[ElemW-1:0];
      y.quo = {x.quo[QuoW-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mi3inv_div.sv =====
// Pipelined restoring divider: 2^44 / |det|, three quotient bits per stage.
// Carries the cofactors alongside; depends on mi3inv_pkg.
`default_nettype none

module mi3inv_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output      logic                      ready_o,
  input  wire logic [31:0]               det_i,
  input  wire mi3inv_pkg::mat_t          cof_i,
  output      logic                      valid_o,
  input  wire logic                      ready_i,
  output      mi3inv_pkg::div_st_t       res_o
);

  localparam int unsigned Stages = mi3inv_pkg::DivStages;
  localparam int unsigned Steps = mi3inv_pkg::DivStepsPerStage;

  mi3inv_pkg::div_st_t src [Stages];
  mi3inv_pkg::div_st_t st_d [Stages];
  mi3inv_pkg::div_st_t st_q [Stages];
  logic [Stages-1:0]   v_q;
  logic [Stages-1:0]   en;

  // Seed stage zero from the determinant, later stages from their predecessor
  always_comb begin
    src[0].rem  = '0;
    src[0].quo  = '0;
    src[0].dmag = det_i[31] ? (32'd0 - det_i) : det_i;
    src[0].neg  = det_i[31];
    src[0].sing = (det_i == 32'd0);
    src[0].cof  = cof_i;
    for (int s = 1; s < Stages; s++) begin
      src[s] = st_q[s-1];
    end
  end

  // Run three dependent steps per stage; only the first global step sees a one
  always_comb begin
    for (int s = 0; s < Stages; s++) begin
      st_d[s] = src[s];
      for (int k = 0; k < Steps; k++) begin
        st_d[s] = mi3inv_pkg::div_step(st_d[s], ((s * Steps + k) == 0));
      end
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[Stages-1] = !v_q[Stages-1] || ready_i;
    for (int s = Stages - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int s = 1; s < Stages; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < Stages; s++) begin
      if (en[s]) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[Stages-1];
  assign res_o   = st_q[Stages-1];

endmodule

`default_nettype wire

// ===== sv/matrix3_inverse_fx12_core.sv =====
// Top level of the 3x3 signed 20.12 fixed-point matrix inverse.
// Depends on mi3inv_pkg and mi3inv_div.
//
// Usage:
//   Input channel s_axis carries one matrix per item, nine 32-bit entries
//   m00..m22 packed row by row from the low bits. Output channel m_axis
//   carries the nine inverse entries in the same order on tdata and the
//   singular flag on tuser; a singular item has all entries zero.
//   The block is a 22-stage pipeline: 4 stages for the cofactor and
//   determinant products, 15 stages of a restoring divider that forms the
//   reciprocal three quotient bits per stage, and 3 stages to scale and
//   round. One item can enter every cycle unless the output is stalled;
//   each stage holds its item while the next one is full, so
//   a stalled receiver fills the pipeline before s_axis_tready drops, and
//   nothing is lost or repeated. Reset clears all valid bits; the block is
//   ready right after reset.
`default_nettype none

module matrix3_inverse_fx12_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // tdata: m00, m01, m02, m10, m11, m12, m20, m21, m22 (32 bits each)
  input  wire logic [287:0] s_axis_tdata,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // tdata: inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22
  output      logic [287:0] m_axis_tdata,
  // tuser: singular
  output      logic         m_axis_tuser,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready
);

  localparam int unsigned N = mi3inv_pkg::NumElem;
  localparam int unsigned W = mi3inv_pkg::ElemW;
  localparam int unsigned PW = mi3inv_pkg::ProdW;
  localparam int unsigned FW = mi3inv_pkg::FracW;

  // pipeline valid bits and enables: pre stages 0..3, post stages 0..2
  logic [3:0] pre_v_q, pre_en;
  logic [2:0] post_v_q, post_en;
  logic       div_ready, div_valid;
  mi3inv_pkg::div_st_t div_res;

  // stage 1: products of the minors
  logic [PW-1:0] pa_d [N], pb_d [N], pa_q [N], pb_q [N];
  logic [W-1:0]  row_q [3];
  // stage 2: cofactors
  mi3inv_pkg::mat_t cof2_d, cof2_q;
  logic [W-1:0]  row2_q [3];
  // stage 3: determinant products
  logic [PW-1:0] dp_d [3], dp_q [3];
  mi3inv_pkg::mat_t cof3_q;
  // stage 4: determinant
  logic [PW-1:0] dsum;
  logic [W-1:0]  det_q;
  mi3inv_pkg::mat_t cof4_q;
  // post stages: reciprocal, scaled products, results
  logic [mi3inv_pkg::QuoW:0]   qs;
  logic [mi3inv_pkg::RecipW-1:0] rsum;
  logic [W-1:0]  recip_q;
  mi3inv_pkg::mat_t cof5_q;
  logic          sing5_q, sing6_q, sing7_q;
  logic [W-1:0]  sp_d [N], sp_q [N];
  mi3inv_pkg::mat_t inv_d, inv_q;

  // Form both products of each minor from the input item
  always_comb begin
    logic signed [2*W-1:0] p;
    logic [W-1:0] a, b, c, d;
    for (int i = 0; i < N; i++) begin
      a = s_axis_tdata[W*mi3inv_pkg::MinA[i] +: W];
      b = s_axis_tdata[W*mi3inv_pkg::MinB[i] +: W];
      c = s_axis_tdata[W*mi3inv_pkg::MinC[i] +: W];
      d = s_axis_tdata[W*mi3inv_pkg::MinD[i] +: W];
      p = $signed(a) * $signed(b);
      pa_d[i] = p[PW-1:0];
      p = $signed(c) * $signed(d);
      pb_d[i] = p[PW-1:0];
    end
  end

  // Subtract, round the first-column minors, keep bits 43:12
  always_comb begin
    logic [PW-1:0] t;
    for (int i = 0; i < N; i++) begin
      t = pa_q[i] - pb_q[i] + (mi3inv_pkg::RoundMask[i] ? mi3inv_pkg::RoundHalf : '0);
      cof2_d[i] = t[PW-1:FW];
    end
  end

  // Expand the determinant along the first row
  always_comb begin
    logic signed [2*W-1:0] p;
    p = $signed(row2_q[0]) * $signed(cof2_q[0]);
    dp_d[0] = p[PW-1:0];
    p = $signed(row2_q[1]) * $signed(cof2_q[3]);
    dp_d[1] = p[PW-1:0];
    p = $signed(row2_q[2]) * $signed(cof2_q[6]);
    dp_d[2] = p[PW-1:0];
  end

  assign dsum = dp_q[0] - dp_q[1] + dp_q[2] + mi3inv_pkg::RoundHalf;

  // Sign the quotient, round it to the 20.12 reciprocal
  assign qs   = div_res.neg ? ('0 - {1'b0, div_res.quo}) : {1'b0, div_res.quo};
  assign rsum = {{(mi3inv_pkg::RecipW - mi3inv_pkg::QuoW - 1){qs[mi3inv_pkg::QuoW]}}, qs}
              + mi3inv_pkg::RecipHalf;

  // Scale each cofactor by the reciprocal
  always_comb begin
    logic signed [2*W-1:0] p;
    for (int i = 0; i < N; i++) begin
      p = $signed(recip_q) * $signed(cof5_q[i]);
      sp_d[i] = p[FW+W-1:FW];
    end
  end

  // Flip odd positions, zero everything for a singular item
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (sing6_q) begin
        inv_d[i] = '0;
      end else if (mi3inv_pkg::NegMask[i]) begin
        inv_d[i] = '0 - sp_q[i];
      end else begin
        inv_d[i] = sp_q[i];
      end
    end
  end

  // Enable chain: a stage advances when empty or when its successor advances
  always_comb begin
    post_en[2] = !post_v_q[2] || m_axis_tready;
    post_en[1] = !post_v_q[1] || post_en[2];
    post_en[0] = !post_v_q[0] || post_en[1];
    pre_en[3]  = !pre_v_q[3] || div_ready;
    pre_en[2]  = !pre_v_q[2] || pre_en[3];
    pre_en[1]  = !pre_v_q[1] || pre_en[2];
    pre_en[0]  = !pre_v_q[0] || pre_en[1];
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q  <= '0;
      post_v_q <= '0;
    end else begin
      if (pre_en[0]) pre_v_q[0] <= s_axis_tvalid;
      if (pre_en[1]) pre_v_q[1] <= pre_v_q[0];
      if (pre_en[2]) pre_v_q[2] <= pre_v_q[1];
      if (pre_en[3]) pre_v_q[3] <= pre_v_q[2];
      if (post_en[0]) post_v_q[0] <= div_valid;
      if (post_en[1]) post_v_q[1] <= post_v_q[0];
      if (post_en[2]) post_v_q[2] <= post_v_q[1];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pre_en[0]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      for (int j = 0; j < 3; j++) begin
        row_q[j] <= s_axis_tdata[W*j +: W];
      end
    end
    if (pre_en[1]) begin
      cof2_q <= cof2_d;
      row2_q <= row_q;
    end
    if (pre_en[2]) begin
      dp_q   <= dp_d;
      cof3_q <= cof2_q;
    end
    if (pre_en[3]) begin
      det_q  <= dsum[PW-1:FW];
      cof4_q <= cof3_q;
    end
    if (post_en[0]) begin
      recip_q <= rsum[mi3inv_pkg::RecipShift +: W];
      cof5_q  <= div_res.cof;
      sing5_q <= div_res.sing;
    end
    if (post_en[1]) begin
      sp_q    <= sp_d;
      sing6_q <= sing5_q;
    end
    if (post_en[2]) begin
      inv_q   <= inv_d;
      sing7_q <= sing6_q;
    end
  end

  mi3inv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pre_v_q[3]),
    .ready_o (div_ready),
    .det_i   (det_q),
    .cof_i   (cof4_q),
    .valid_o (div_valid),
    .ready_i (post_en[0]),
    .res_o   (div_res)
  );

  assign s_axis_tready = pre_en[0];
  assign m_axis_tvalid = post_v_q[2];
  assign m_axis_tuser  = sing7_q;
  assign m_axis_tdata  = inv_q;

endmodule

`default_nettype wire

// ===== sv/mi3inv_chk.sv =====
// Port-level checker for matrix3_inverse_fx12_core, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module mi3inv_chk (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready,
  input wire logic [287:0] m_axis_tdata,
  input wire logic         m_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output item changed");

  // A singular item carries all-zero entries
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("singular item with nonzero entries");

  // Reset clears the output valid
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // An empty output stage lets the whole pipeline advance
  a_ready: assert property (@(posedge clk_i) !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

endmodule

bind matrix3_inverse_fx12_core mi3inv_chk u_mi3inv_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

// ===== tb/matrix3_inverse_fx12_core_tb.sv =====
// Self-checking bench for the 3x3 signed 20.12 fixed-point matrix inverse core.
// Depends on mi3inv_pkg and matrix3_inverse_fx12_core; predicts each inverse in place.
`default_nettype none

module matrix3_inverse_fx12_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PipeLat = 22;
  localparam longint unsigned CycleLimit = 400000;

  typedef struct {
    logic [287:0] entries;
    logic         singular;
  } inverse_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [287:0] s_axis_tdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;

  inverse_t        expected_inverses[$];
  int unsigned     error_count = 0;
  longint unsigned cycle_count = 0;
  bit              hold_off = 1'b0;
  int unsigned     hold_cycles = 0;
  int unsigned     burst_left = 0;

  matrix3_inverse_fx12_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always #4 clk_i = ~clk_i;

  // Minor (a*b - c*d + rnd) >>> 12, low 32 bits.
  function automatic logic [31:0] minor_fx(logic [31:0] a, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d,
                                           logic [63:0] rnd);
    logic signed [63:0] acc;
    acc = $signed(64'($signed(a)) * 64'($signed(b)))
        - $signed(64'($signed(c)) * 64'($signed(d))) + $signed(rnd);
    return 32'(acc >>> 12);
  endfunction

  // Scale one cofactor by the reciprocal, negate for odd positions.
  function automatic logic [31:0] scale_fx(logic [31:0] recip, logic [31:0] cof, bit neg);
    logic signed [63:0] prod;
    logic [31:0]        v;
    prod = 64'($signed(recip)) * 64'($signed(cof));
    v = 32'(prod >>> 12);
    return neg ? 32'(0) - v : v;
  endfunction

  function automatic inverse_t predict_inverse(logic [287:0] mat);
    logic [31:0]        m [9];
    logic [31:0]        cof [9];
    logic [31:0]        det;
    logic signed [63:0] acc;
    logic signed [63:0] quo;
    logic [63:0]        qr;
    logic [31:0]        recip;
    inverse_t           res;
    for (int i = 0; i < 9; i++) m[i] = mat[32*i +: 32];
    cof[0] = minor_fx(m[4], m[8], m[5], m[7], 64'h800);
    cof[3] = minor_fx(m[3], m[8], m[5], m[6], 64'h800);
    cof[6] = minor_fx(m[3], m[7], m[4], m[6], 64'h800);
    acc = $signed(64'($signed(m[0])) * 64'($signed(cof[0])))
        - $signed(64'($signed(m[1])) * 64'($signed(cof[3])))
        + $signed(64'($signed(m[2])) * 64'($signed(cof[6]))) + 64'sh800;
    det = 32'(acc >>> 12);
    res.entries = '0;
    res.singular = (det == 32'd0);
    if (res.singular) return res;
    quo = (64'sd1 <<< 44) / 64'($signed(det));
    qr = 64'(quo) + (64'd1 << 19);
    recip = 32'($signed(qr) >>> 20);
    cof[1] = minor_fx(m[1], m[8], m[7], m[2], 64'd0);
    cof[2] = minor_fx(m[1], m[5], m[4], m[2], 64'd0);
    cof[4] = minor_fx(m[0], m[8], m[6], m[2], 64'd0);
    cof[5] = minor_fx(m[0], m[5], m[3], m[2], 64'd0);
    cof[7] = minor_fx(m[0], m[7], m[6], m[1], 64'd0);
    cof[8] = minor_fx(m[0], m[4], m[3], m[1], 64'd0);
    for (int i = 0; i < 9; i++) res.entries[32*i +: 32] = scale_fx(recip, cof[i], i % 2 == 1);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
  endtask

  // Offer one matrix, hold until accepted; gaps come from the burst pattern.
  task automatic send_matrix(logic [287:0] mat);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tdata  <= mat;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_inverses.push_back(predict_inverse(mat));
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 16'hffff)) - 32768);
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      default: return 32'($signed($urandom_range(0, 24'h3ffff)) - 32'sh1ffff);
    endcase
  endfunction

  function automatic logic [287:0] rand_matrix();
    logic [287:0] mat;
    for (int i = 0; i < 9; i++) mat[32*i +: 32] = rand_entry();
    return mat;
  endfunction

  // Corners, identity, scaled diagonals and singular cases.
  task automatic test_directed();
    logic [287:0] mat;
    send_matrix('0);
    send_matrix({9{32'h7fffffff}});
    send_matrix({9{32'h80000000}});
    send_matrix({9{32'hffffffff}});
    mat = '0;
    mat[0 +: 32] = 32'h1000; mat[128 +: 32] = 32'h1000; mat[256 +: 32] = 32'h1000;
    send_matrix(mat);
    mat[0 +: 32] = 32'h2000; mat[128 +: 32] = 32'hfffff000; mat[256 +: 32] = 32'h800;
    send_matrix(mat);
    mat[0 +: 32] = 32'h1; mat[128 +: 32] = 32'h1000; mat[256 +: 32] = 32'h1000;
    send_matrix(mat);
    mat[0 +: 32] = 32'h7fffffff; mat[128 +: 32] = 32'h7fffffff; mat[256 +: 32] = 32'h80000000;
    send_matrix(mat);
    for (int k = 0; k < 3; k++) begin
      mat = rand_matrix();
      mat[96 +: 96] = mat[0 +: 96];
      send_matrix(mat);
    end
    send_matrix({32'h1000, 32'h5555aaaa, 32'haaaa5555, 32'h0, 32'h1000, 32'h12345678,
                 32'h0, 32'h0, 32'h1000});
    for (int k = 0; k < 8; k++) send_matrix({9{32'($urandom_range(1, 32'h3000))}} ^ rand_matrix());
  endtask

  // Well-conditioned matrices near the identity plus raw noise.
  task automatic test_random(int unsigned count);
    logic [287:0] mat;
    for (int unsigned k = 0; k < count; k++) begin
      mat = rand_matrix();
      if ($urandom_range(0, 3) != 0) begin
        mat[0 +: 32] += 32'($urandom_range(1, 8)) << 12;
        mat[128 +: 32] += 32'($urandom_range(1, 8)) << 12;
        mat[256 +: 32] += 32'($urandom_range(1, 8)) << 12;
      end
      send_matrix(mat);
    end
  endtask

  // Receiver blocks for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_cycles = 200;
    hold_off = 1'b1;
    test_random(80);
    wait (!hold_off);
  endtask

  // Receiver stall pattern and long hold-off.
  always @(negedge clk_i) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
      if (hold_cycles == 0) hold_off <= 1'b0;
      else hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= (cycle_count % 512 < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    inverse_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_inverses.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = expected_inverses.pop_front();
        for (int i = 0; i < 9; i++)
          if (m_axis_tdata[32*i +: 32] !== want.entries[32*i +: 32])
            report_mismatch($sformatf("inv%0d%0d", i / 3, i % 3),
                            m_axis_tdata[32*i +: 32], want.entries[32*i +: 32]);
        if (m_axis_tuser !== want.singular)
          report_mismatch("singular", 32'(m_axis_tuser), 32'(want.singular));
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(900);
    test_backpressure();
    test_random(800);
    s_axis_tvalid <= 1'b0;
    wait (expected_inverses.size() == 0);
    repeat (PipeLat + 10) @(negedge clk_i);
    if (error_count == 0 && expected_inverses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
